// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define MDOR_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// consequent holds at the same edge as the antecedent
`define MDOR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds at the edge after the antecedent
`define MDOR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mdor_pkg.sv =====
// ----------------------------------------------------------------------------
// mdor_pkg
// Widths, register indexes and shared types of the mesh route decision block.
// ----------------------------------------------------------------------------
package mdor_pkg;

   localparam int MOD_BITS      = 3;
   localparam int NUM_SIZE_REGS = 4;

   localparam int SRC_W       = 12;
   localparam int DEST_W      = 13;
   localparam int ID_W        = 18;
   localparam int PORT_W      = 4;
   localparam int PORT_CALC_W = PORT_W + 1;
   localparam int DIMS_W      = 3;
   localparam int SIZE_W      = 7;
   localparam int CSR_IDX_W   = 3;

   // widest current node: id with the smallest module field removed
   localparam int CUR_W   = ID_W - (MOD_BITS + 2);
   localparam int RADIX_W = CUR_W + 1;
   localparam int PROD_W  = 2 * RADIX_W;

   // any radix at or above this leaves every node value unchanged under mod
   localparam logic [RADIX_W-1:0] RADIX_CAP = {1'b1, {CUR_W{1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DIMS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_0   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_3   = 3'd4;

   // low bits of an exit demux id: type field of a demux
   localparam logic [1:0] EXIT_TYPE = 2'b10;

   typedef logic [RADIX_W-1:0] radix_type;

   typedef struct packed {
      logic [DIMS_W-1:0]                     num_dims;
      logic [NUM_SIZE_REGS:1][RADIX_W-1:0]   radix;
   } cfg_type;

   function automatic radix_type cap_radix(input logic [PROD_W-1:0] prod);
      radix_type r;
      if (prod > {{(PROD_W-RADIX_W){1'b0}}, RADIX_CAP}) begin
         r = RADIX_CAP;
      end else begin
         r = prod[RADIX_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/mdor_csr.sv =====
// ----------------------------------------------------------------------------
// mdor_csr
// Configuration registers and the per-dimension radix products built from
// them. Each product is registered behind the registers it is built from.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdor_csr import mdor_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_data,
   output cfg_type              cfg
);

   localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd2;

   logic [DIMS_W-1:0] num_dims_ff, num_dims_in;
   logic [SIZE_W-1:0] size_ff [NUM_SIZE_REGS];
   logic [SIZE_W-1:0] size_in [NUM_SIZE_REGS];
   logic [SIZE_W-1:0] size_eff [NUM_SIZE_REGS];

   radix_type         r2_ff, r2_in;
   radix_type         p23_ff, p23_in;
   radix_type         r3_ff, r3_in;
   radix_type         r4_ff, r4_in;
   logic [PROD_W-1:0] p23_prod;

   assign csr_ready = 1'b1;

   always_comb begin
      num_dims_in = num_dims_ff;
      size_in     = size_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NUM_DIMS: num_dims_in = csr_data[DIMS_W-1:0];
            CSR_SIZE_0:   size_in[0]  = csr_data;
            CSR_SIZE_1:   size_in[1]  = csr_data;
            CSR_SIZE_2:   size_in[2]  = csr_data;
            CSR_SIZE_3:   size_in[3]  = csr_data;
            default: ;
         endcase
      end
   end

   // a zero size acts as one
   always_comb begin
      for (int i = 0; i < NUM_SIZE_REGS; i++) begin
         size_eff[i] = (size_ff[i] == '0) ? SIZE_W'(1) : size_ff[i];
      end
   end

   assign p23_prod = PROD_W'(size_eff[2]) * PROD_W'(size_eff[3]);
   assign r2_in  = cap_radix(PROD_W'(size_eff[0]) * PROD_W'(size_eff[1]));
   assign p23_in = p23_prod[RADIX_W-1:0];
   assign r3_in  = cap_radix(PROD_W'(r2_ff) * PROD_W'(size_eff[2]));
   assign r4_in  = cap_radix(PROD_W'(r2_ff) * PROD_W'(p23_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= DIMS_RESET;
         size_ff     <= '{SIZE_W'(4), SIZE_W'(4), SIZE_W'(1), SIZE_W'(1)};
         r2_ff       <= RADIX_W'(16);
         p23_ff      <= RADIX_W'(1);
         r3_ff       <= RADIX_W'(16);
         r4_ff       <= RADIX_W'(16);
      end else begin
         num_dims_ff <= num_dims_in;
         size_ff     <= size_in;
         r2_ff       <= r2_in;
         p23_ff      <= p23_in;
         r3_ff       <= r3_in;
         r4_ff       <= r4_in;
      end
   end

   always_comb begin
      cfg.num_dims  = num_dims_ff;
      cfg.radix[1]  = RADIX_W'(size_eff[0]);
      cfg.radix[2]  = r2_ff;
      cfg.radix[3]  = r3_ff;
      cfg.radix[4]  = r4_ff;
   end

   `MDOR_ASSERT_NEXT(a_dims_write, csr_valid && csr_ready && csr_index == CSR_NUM_DIMS,
      cfg.num_dims == $past(csr_data[DIMS_W-1:0]), "dimension count write not taken")
   `MDOR_ASSERT(a_radix_nonzero, cfg.radix[2] != '0 && cfg.radix[3] != '0 && cfg.radix[4] != '0,
      "radix product went to zero")

endmodule

// ===== rtl/mesh_dimension_order_route_top.sv =====
// ----------------------------------------------------------------------------
// mesh_dimension_order_route_top
// Exit port decision of one demux in a non-wraparound n-dimensional mesh with
// dimension-ordered routing, highest dimension first.
// A request (req_*) carries source node, destination word and demux id; one
// response (rsp_*) per request carries the exit port and the self-send flag.
// Both channels are valid/ready. Registers are written over csr_* (always
// ready); the user must write them only while no request is in flight, and
// the block itself does not enforce it. A request passes the input register,
// decode, five remainder stages of three restoring steps each, and the output
// register before rsp_valid rises. One request per cycle is taken while the
// response side does not stall. A stalled response holds the output register;
// stages behind it keep filling bubbles, so req_ready drops only when every
// stage holds a request. Reset empties the pipeline and loads 2 dimensions of
// sizes 4, 4, 1, 1. Radix products are registered behind the size registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mesh_dimension_order_route_top import mdor_pkg::*; #(
   parameter int MAX_DIMS  = 4,
   parameter int NODE_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [SRC_W-1:0]     req_source_node,
   input  logic [DEST_W-1:0]    req_dest_word,
   input  logic [ID_W-1:0]      req_module_id,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PORT_W-1:0]    rsp_exit_port,
   output logic                 rsp_self_send,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_data
);

   localparam int LOG_MAX    = (MAX_DIMS <= 2) ? 1 : ((MAX_DIMS <= 4) ? 2 : 3);
   localparam int LOW_W      = MOD_BITS + 1 + LOG_MAX;
   localparam int SHIFT_W    = $clog2(LOW_W + 1);
   localparam int LANES      = (MAX_DIMS > 1) ? MAX_DIMS - 1 : 1;
   localparam int DIM_W      = (MAX_DIMS > 2) ? $clog2(MAX_DIMS) : 1;
   localparam int STEP       = 3;
   localparam int DIV_STAGES = (CUR_W + STEP - 1) / STEP;
   localparam int PAD_W      = DIV_STAGES * STEP;
   localparam int STAGES     = DIV_STAGES + 3;

   typedef struct packed {
      logic              self_send;
      logic              arrived;
      logic [DIMS_W-1:0] dims;
      logic              dir;
      logic [LOW_W-1:0]  low_id;
      logic [CUR_W-1:0]  span;
   } item_type;

   cfg_type cfg;

   mdor_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // dimension count in use
   logic [DIMS_W-1:0]      dims_cfg;
   logic [PORT_CALC_W-1:0] self_port_cfg;

   always_comb begin
      if (cfg.num_dims == '0) begin
         dims_cfg = DIMS_W'(1);
      end else if (int'(cfg.num_dims) > MAX_DIMS) begin
         dims_cfg = DIMS_W'(MAX_DIMS);
      end else begin
         dims_cfg = cfg.num_dims;
      end
   end

   assign self_port_cfg = PORT_CALC_W'(dims_cfg) << 1;

   radix_type radix_lane [LANES];

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      localparam int RI = (l + 1 < NUM_SIZE_REGS) ? l + 1 : NUM_SIZE_REGS;
      assign radix_lane[l] = cfg.radix[RI];
   end

   // pipeline control: stage 0 input, 1 decode, 2.. remainder, last output
   logic [STAGES-1:0] valid_ff, valid_in, stage_en;

   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // input register
   logic [SRC_W-1:0]  src_ff;
   logic [DEST_W-1:0] dest_ff;
   logic [ID_W-1:0]   id_ff;

   // decode
   logic [NODE_BITS-1:0] src_node, dst_node;
   logic [CUR_W-1:0]     dest_ext, cur, hi, lo;
   logic [SHIFT_W-1:0]   id_shift;
   logic [ID_W-1:0]      low_mask;
   logic [ID_W-1:0]      low_full;
   item_type             item_s1_in;
   logic [PAD_W-1:0]     sh_s1_in;

   always_comb begin
      src_node  = src_ff[NODE_BITS-1:0];
      dst_node  = dest_ff[NODE_BITS-1:0];
      dest_ext  = CUR_W'(dst_node);
      if (dims_cfg <= DIMS_W'(2)) begin
         id_shift = SHIFT_W'(MOD_BITS + 2);
      end else if (dims_cfg <= DIMS_W'(4)) begin
         id_shift = SHIFT_W'(MOD_BITS + 3);
      end else begin
         id_shift = SHIFT_W'(MOD_BITS + 4);
      end
      cur      = CUR_W'(id_ff >> id_shift);
      low_mask = (ID_W'(1) << id_shift) - ID_W'(1);
      low_full = id_ff & low_mask;

      item_s1_in.self_send = (src_node == dst_node);
      item_s1_in.arrived   = (cur == dest_ext);
      item_s1_in.dir       = (cur < dest_ext);
      item_s1_in.dims      = dims_cfg;
      item_s1_in.low_id    = low_full[LOW_W-1:0];
      hi = item_s1_in.dir ? dest_ext : cur;
      lo = item_s1_in.dir ? cur : dest_ext;
      item_s1_in.span = hi - lo;
      sh_s1_in        = PAD_W'(hi);
   end

   // Dimension d differs iff a multiple of its radix lies in (lo, hi],
   // i.e. hi mod radix < hi - lo. Remainders come from restoring steps.
   item_type         item_ff [DIV_STAGES+1];
   logic [PAD_W-1:0] sh_ff   [DIV_STAGES];
   radix_type        rem_ff  [DIV_STAGES][LANES];
   radix_type        rem_next [DIV_STAGES][LANES];

   always_comb begin
      logic [PAD_W-1:0] sh_w;
      radix_type        trial;
      for (int k = 0; k < DIV_STAGES; k++) begin
         sh_w = sh_ff[k];
         for (int l = 0; l < LANES; l++) begin
            rem_next[k][l] = (k == 0) ? '0 : rem_ff[(k == 0) ? 0 : k - 1][l];
         end
         for (int j = 0; j < STEP; j++) begin
            for (int l = 0; l < LANES; l++) begin
               trial = {rem_next[k][l][RADIX_W-2:0], sh_w[PAD_W-1]};
               if (trial >= radix_lane[l]) begin
                  trial = trial - radix_lane[l];
               end
               rem_next[k][l] = trial;
            end
            sh_w = sh_w << 1;
         end
      end
   end

   // result
   item_type               it;
   logic [DIM_W-1:0]       dim;
   logic [ID_W-1:0]        exit_id;
   logic [PORT_CALC_W-1:0] two_n, port_calc;
   logic [PORT_W-1:0]      port_ff, port_in;
   logic                   self_ff;

   always_comb begin
      it  = item_ff[DIV_STAGES];
      dim = '0;
      for (int l = 0; l < LANES; l++) begin
         if ((l + 1) < int'(it.dims) &&
             rem_ff[DIV_STAGES-1][l] < RADIX_W'(it.span)) begin
            dim = DIM_W'(l + 1);
         end
      end
      two_n     = PORT_CALC_W'(it.dims) << 1;
      exit_id   = (ID_W'(dim) << MOD_BITS) | (ID_W'(it.dir) << (MOD_BITS - 1)) |
                  ID_W'(EXIT_TYPE);
      port_calc = (PORT_CALC_W'(dim) << 1) | PORT_CALC_W'(it.dir);
      if (exit_id > ID_W'(it.low_id) && port_calc != '0) begin
         port_calc = port_calc - PORT_CALC_W'(1);
      end
      if (it.self_send) begin
         port_calc = two_n;
      end else if (it.arrived) begin
         port_calc = two_n - PORT_CALC_W'(1);
      end
      port_in = port_calc[PORT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         src_ff  <= req_source_node;
         dest_ff <= req_dest_word;
         id_ff   <= req_module_id;
      end
      if (stage_en[1]) begin
         item_ff[0] <= item_s1_in;
         sh_ff[0]   <= sh_s1_in;
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
         if (stage_en[k+1]) begin
            item_ff[k]  <= item_ff[k-1];
            rem_ff[k-1] <= rem_next[k-1];
         end
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
         if (stage_en[k+1]) begin
            sh_ff[k] <= sh_ff[k-1] << STEP;
         end
      end
      if (stage_en[STAGES-1]) begin
         port_ff <= port_in;
         self_ff <= it.self_send;
      end
   end

   assign rsp_exit_port = port_ff;
   assign rsp_self_send = self_ff;

   `MDOR_ASSERT_NEXT(a_decode_hold, valid_ff[1] && !stage_en[1],
      valid_ff[1] && $stable(sh_ff[0]), "stalled decode stage changed")
   `MDOR_ASSERT_SAME(a_self_port, rsp_valid && rsp_self_send,
      rsp_exit_port == self_port_cfg[PORT_W-1:0], "self-send port is not 2*dims")
   `MDOR_ASSERT_SAME(a_port_range, rsp_valid && !rsp_self_send,
      PORT_CALC_W'(rsp_exit_port) < self_port_cfg, "exit port beyond mesh ports")

endmodule

// ===== sim/mesh_route_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_route_checker
// Passive checker for the mesh route decision block. Tracks register writes,
// predicts exit port and self-send flag of each accepted request, and checks
// responses against the predictions in order.
// ----------------------------------------------------------------------------
module mesh_route_checker import mdor_pkg::*; #(
   parameter int MAX_DIMS  = 4,
   parameter int NODE_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [SRC_W-1:0]     req_source_node,
   input  logic [DEST_W-1:0]    req_dest_word,
   input  logic [ID_W-1:0]      req_module_id,

   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [PORT_W-1:0]    rsp_exit_port,
   input  logic                 rsp_self_send,

   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_data,

   output int                   route_errors,
   output int                   routes_pending
);

   typedef struct packed {
      logic [PORT_W-1:0] exit_port;
      logic              self_send;
   } route_type;

   logic [DIMS_W-1:0] dims_reg;
   logic [SIZE_W-1:0] size_reg [NUM_SIZE_REGS];
   route_type         expected_routes [$];
   int                errors = 0;

   // a zero size, or a dimension without a register, counts as one node
   function automatic longint unsigned dim_nodes(input int unsigned d);
      longint unsigned s;
      s = 1;
      if (d < NUM_SIZE_REGS && size_reg[d] != '0) begin
         s = size_reg[d];
      end
      return s;
   endfunction

   function automatic route_type predict_exit(input logic [SRC_W-1:0]  src,
                                              input logic [DEST_W-1:0] dest_word,
                                              input logic [ID_W-1:0]   id);
      longint unsigned node_mask, dst, cur, low_id, radix, cdig, ddig, exit_id, port;
      int unsigned     n, lg, span, shift, dim, dir;
      int              i;
      bit              found;
      route_type       r;

      node_mask = (longint'(1) << NODE_BITS) - 1;
      dst = dest_word & node_mask;
      n = (dims_reg == 0) ? 1 : ((dims_reg > MAX_DIMS) ? MAX_DIMS : dims_reg);
      lg = 1;
      span = 2;
      while (span < n) begin
         span *= 2;
         lg++;
      end
      shift = MOD_BITS + lg + 1;
      cur = id >> shift;
      low_id = id & ((longint'(1) << shift) - 1);
      r.self_send = 1'b0;

      if ((src & node_mask) == dst) begin
         r.exit_port = PORT_W'(2 * n);
         r.self_send = 1'b1;
      end else if (cur == dst) begin
         r.exit_port = PORT_W'(2 * n - 1);
      end else begin
         radix = 1;
         for (int d = 0; d < n; d++) begin
            radix *= dim_nodes(d);
         end
         // walk digits from the highest dimension down to the first difference
         found = 1'b0;
         dim = 0;
         cdig = 0;
         ddig = 0;
         for (i = int'(n) - 1; i >= 0 && !found; i--) begin
            radix = radix / dim_nodes(i);
            cdig = cur / radix;
            ddig = dst / radix;
            dim = i;
            if (cdig != ddig) begin
               found = 1'b1;
            end else begin
               cur = cur % radix;
               dst = dst % radix;
            end
         end
         dir = (cdig < ddig) ? 1 : 0;
         exit_id = (longint'(dim) << MOD_BITS) | (longint'(dir) << (MOD_BITS - 1)) | EXIT_TYPE;
         port = 2 * dim + dir;
         if (exit_id > low_id) begin
            port = (port == 0) ? 0 : port - 1;
         end
         r.exit_port = PORT_W'(port);
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      route_type want;
      if (reset) begin
         dims_reg = 3'd2;
         size_reg[0] = 7'd4;
         size_reg[1] = 7'd4;
         size_reg[2] = 7'd1;
         size_reg[3] = 7'd1;
         expected_routes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_routes.size() == 0) begin
               if (errors < 10) begin
                  $display("%0t: response with no request waiting: exit_port %0d self_send %b",
                           $time, rsp_exit_port, rsp_self_send);
               end
               errors++;
            end else begin
               want = expected_routes.pop_front();
               if (rsp_exit_port !== want.exit_port || rsp_self_send !== want.self_send) begin
                  if (errors < 10) begin
                     $display("%0t: exit_port %0d (expected %0d), self_send %b (expected %b)",
                              $time, rsp_exit_port, want.exit_port,
                              rsp_self_send, want.self_send);
                  end
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NUM_DIMS: dims_reg = csr_data[DIMS_W-1:0];
               CSR_SIZE_0:   size_reg[0] = csr_data;
               CSR_SIZE_1:   size_reg[1] = csr_data;
               CSR_SIZE_2:   size_reg[2] = csr_data;
               CSR_SIZE_3:   size_reg[3] = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_routes.push_back(predict_exit(req_source_node, req_dest_word,
                                                   req_module_id));
         end
      end
      routes_pending <= expected_routes.size();
      route_errors <= errors;
   end

endmodule

// ===== sim/mesh_dimension_order_route_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_dimension_order_route_top_tb
// Drives route requests through a series of mesh shapes, from the reset shape
// to degenerate and oversized ones, with bursty requests and a stalling
// response side. The checker predicts and compares every response.
// ----------------------------------------------------------------------------
module mesh_dimension_order_route_top_tb;
   import mdor_pkg::*;

   localparam int MAX_DIMS       = 4;
   localparam int NODE_BITS      = 12;
   localparam int PHASE_REQUESTS = 150;
   localparam int IDLE_LIMIT     = 2000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int DRAIN_CYCLES   = 20;

   typedef enum int {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_PERIODIC} sink_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [SRC_W-1:0]     req_source_node = '0;
   logic [DEST_W-1:0]    req_dest_word = '0;
   logic [ID_W-1:0]      req_module_id = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [PORT_W-1:0]    rsp_exit_port;
   logic                 rsp_self_send;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_NUM_DIMS;
   logic [SIZE_W-1:0]    csr_data = '0;

   int route_errors;
   int routes_pending;

   // mesh shape as the stimulus sees it
   int unsigned shape_size [NUM_SIZE_REGS];
   int unsigned mesh_dims_used;
   int unsigned mesh_nodes;
   int unsigned id_shift;

   int            burst_left = 0;
   int            idle_cycles = 0;
   int unsigned   sink_tick = 0;
   sink_mode_type sink_mode = SINK_OPEN;

   mesh_dimension_order_route_top #(
      .MAX_DIMS  (MAX_DIMS),
      .NODE_BITS (NODE_BITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_source_node (req_source_node),
      .req_dest_word   (req_dest_word),
      .req_module_id   (req_module_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_exit_port   (rsp_exit_port),
      .rsp_self_send   (rsp_self_send),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   mesh_route_checker #(
      .MAX_DIMS  (MAX_DIMS),
      .NODE_BITS (NODE_BITS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_source_node (req_source_node),
      .req_dest_word   (req_dest_word),
      .req_module_id   (req_module_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_exit_port   (rsp_exit_port),
      .rsp_self_send   (rsp_self_send),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .route_errors    (route_errors),
      .routes_pending  (routes_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: stall pattern switches at random among four sink modes
   always @(posedge clock) begin
      sink_tick <= sink_tick + 1;
      if (sink_tick % 64 == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 3));
      end
      case (sink_mode)
         SINK_OPEN:   rsp_ready <= 1'b1;
         SINK_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
         SINK_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_ready <= (sink_tick % 8) < 5;
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("** mesh_dimension_order_route_top: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic void shape_for(input logic [DIMS_W-1:0] dims,
                                     input logic [SIZE_W-1:0] s0, s1, s2, s3);
      longint unsigned prod;
      shape_size[0] = (s0 == 0) ? 1 : s0;
      shape_size[1] = (s1 == 0) ? 1 : s1;
      shape_size[2] = (s2 == 0) ? 1 : s2;
      shape_size[3] = (s3 == 0) ? 1 : s3;
      mesh_dims_used = (dims == 0) ? 1 : ((dims > MAX_DIMS) ? MAX_DIMS : dims);
      id_shift = MOD_BITS + ((mesh_dims_used <= 2) ? 1 : 2) + 1;
      prod = 1;
      for (int j = 0; j < mesh_dims_used; j++) begin
         prod *= shape_size[j];
      end
      mesh_nodes = (prod > (1 << NODE_BITS)) ? (1 << NODE_BITS) : 32'(prod);
   endfunction

   // drop valid and hold off until every response is back
   task automatic wait_for_routes();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (routes_pending != 0);
   endtask

   task automatic push_route(input logic [SRC_W-1:0]  src,
                             input logic [DEST_W-1:0] dest,
                             input logic [ID_W-1:0]   id);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_source_node <= src;
      req_dest_word <= dest;
      req_module_id <= id;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic reconfigure(input logic [DIMS_W-1:0] dims,
                              input logic [SIZE_W-1:0] s0, s1, s2, s3,
                              input bit                junk);
      logic [CSR_IDX_W-1:0] idx [6];
      logic [SIZE_W-1:0]    val [6];
      int                   count;
      idx[0] = CSR_NUM_DIMS;
      val[0] = {4'($urandom), dims};
      idx[1] = CSR_SIZE_0;
      val[1] = s0;
      idx[2] = CSR_SIZE_1;
      val[2] = s1;
      idx[3] = CSR_SIZE_2;
      val[3] = s2;
      idx[4] = CSR_SIZE_3;
      val[4] = s3;
      // an index past the last register should change nothing
      idx[5] = CSR_SIZE_3 + CSR_IDX_W'($urandom_range(1, 3));
      val[5] = SIZE_W'($urandom);
      count = junk ? 6 : 5;
      wait_for_routes();
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int k = 0; k < count; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data <= val[k];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      // radix products lag a size write
      repeat (3) @(posedge clock);
      shape_for(dims, s0, s1, s2, s3);
   endtask

   task automatic random_request();
      longint unsigned dst, src, cur, low, stride, digit;
      int unsigned     pick, sel, k;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         push_route(SRC_W'($urandom), DEST_W'($urandom), ID_W'($urandom));
      end else begin
         dst = $urandom_range(0, mesh_nodes - 1);
         src = (pick < 20) ? dst : $urandom_range(0, mesh_nodes - 1);
         sel = $urandom_range(0, 99);
         if (sel < 15) begin
            cur = dst;
         end else if (sel < 55) begin
            // at most one hop away along a single dimension
            k = $urandom_range(0, mesh_dims_used - 1);
            stride = 1;
            for (int j = 0; j < k; j++) begin
               stride *= shape_size[j];
            end
            digit = (dst / stride) % shape_size[k];
            cur = dst;
            if ($urandom_range(0, 1) && digit + 1 < shape_size[k]) begin
               cur = dst + stride;
            end else if (digit > 0) begin
               cur = dst - stride;
            end
         end else if (sel < 60) begin
            cur = $urandom_range(mesh_nodes, (1 << (ID_W - id_shift)) - 1);
         end else begin
            cur = $urandom_range(0, mesh_nodes - 1);
         end
         if ($urandom_range(0, 1)) begin
            low = ($urandom_range(0, mesh_dims_used - 1) << MOD_BITS) | $urandom_range(0, 7);
         end else begin
            low = $urandom_range(0, (1 << id_shift) - 1);
         end
         push_route(SRC_W'(src), {1'($urandom), NODE_BITS'(dst)},
                    ID_W'((cur << id_shift) | low));
      end
   endtask

   task automatic run_traffic(input int count);
      for (int k = 0; k < count; k++) begin
         if (k == count / 2) begin
            wait_for_routes();
         end
         random_request();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (reset);
      shape_for(3'd2, 7'd4, 7'd4, 7'd1, 7'd1);

      // reset shape: 4x4 mesh, node field from bit 5 up
      push_route(12'd5, 13'd5, 18'd0);
      push_route(12'd4095, 13'd8191, 18'd262143);
      push_route(12'd0, 13'h1000, 18'd0);
      push_route(12'd1, 13'd9, (18'd9 << 5) | 18'd2);
      push_route(12'd4095, 13'd0, 18'd0);
      push_route(12'd0, 13'd1, 18'd0);
      push_route(12'd3, 13'd0, (18'd1 << 5));
      push_route(12'd0, 13'd15, 18'd31);
      push_route(12'd0, 13'd15, 18'd8);
      push_route(12'd15, 13'd0, (18'd15 << 5) | 18'd10);
      push_route(12'd1, 13'd3, 18'd262143);
      push_route(12'd2, 13'd4095, (18'd5 << 5) | 18'd14);
      push_route(12'd0, 13'd4095, 18'd262143);
      run_traffic(PHASE_REQUESTS - 13);

      reconfigure(3'd1, 7'd64, 7'd1, 7'd1, 7'd1, 1'b0);
      run_traffic(PHASE_REQUESTS);
      reconfigure(3'd4, 7'd8, 7'd8, 7'd8, 7'd8, 1'b0);
      run_traffic(PHASE_REQUESTS);
      reconfigure(3'd4, 7'd1, 7'd1, 7'd1, 7'd1, 1'b1);
      run_traffic(PHASE_REQUESTS);
      reconfigure(3'd3, 7'd16, 7'd16, 7'd16, 7'd1, 1'b0);
      run_traffic(PHASE_REQUESTS);
      reconfigure(3'd2, 7'd64, 7'd64, 7'd5, 7'd7, 1'b0);
      run_traffic(PHASE_REQUESTS);
      reconfigure(3'd0, 7'd0, 7'd3, 7'd0, 7'd0, 1'b1);
      run_traffic(PHASE_REQUESTS);
      reconfigure(3'd7, 7'd127, 7'd127, 7'd127, 7'd127, 1'b1);
      run_traffic(PHASE_REQUESTS);
      reconfigure(3'd4, 7'd64, 7'd64, 7'd64, 7'd64, 1'b0);
      run_traffic(PHASE_REQUESTS);
      reconfigure(3'd3, 7'd2, 7'd3, 7'd5, 7'd0, 1'b0);
      run_traffic(PHASE_REQUESTS);
      for (int p = 0; p < 3; p++) begin
         reconfigure(DIMS_W'($urandom), SIZE_W'($urandom_range(0, 9)),
                     SIZE_W'($urandom_range(0, 9)), SIZE_W'($urandom_range(0, 9)),
                     SIZE_W'($urandom_range(0, 9)), 1'($urandom));
         run_traffic(PHASE_REQUESTS);
      end

      wait_for_routes();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (route_errors == 0) begin
         $display("** mesh_dimension_order_route_top: PASSED **");
      end else begin
         $display("** mesh_dimension_order_route_top: FAILED **");
      end
      $finish;
   end

endmodule
